[rtl/any_base_radix_converter_defines.svh]
// Assertion macros shared by the radix converter RTL.
// Standalone header; the assertions drop out when SYNTHESIS is defined.
`ifndef ANY_BASE_RADIX_CONVERTER_DEFINES_SVH
`define ANY_BASE_RADIX_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define ABRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ABRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ABRC_ASSERT(label, clk, rst, prop, msg)
`define ABRC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/abrc_pkg.sv]
// Shared types and constants of the radix converter.
// No dependencies; imported by the controller, the datapath and the top level.
package abrc_pkg;

   localparam int N_W        = 31;   // coded input number
   localparam int ACC_W      = 34;   // value and weight stay within 10^10, below 2^34
   localparam int SB_W       = 4;
   localparam int TB_W       = 5;
   localparam int DIGIT_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int CFG_IDX_W  = 1;
   localparam int CFG_DATA_W = 5;
   localparam int DIV_STEP   = 4;    // quotient bits per divider cycle

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_DIGITS_DEF  = 32;

   // floor(n / 10) == (n * RECIP_10) >> RECIP_SHIFT for any n below 2^32
   localparam int RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [SB_W-1:0] SB_MIN = 4'd2;
   localparam logic [SB_W-1:0] SB_MAX = 4'd10;
   localparam logic [TB_W-1:0] TB_MIN = 5'd2;
   localparam logic [TB_W-1:0] TB_MAX = 5'd16;

   localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 1'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 1'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_DIGIT = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic       load_item;
      logic       mul;
      logic       acc;
      logic       load_div;
      logic       div_step;
      logic       load_digit;
      logic       dec_idx;
      logic       load_err;
      status_type err_code;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic bad_digit;
      logic overflow;
      logic div_last;
      logic quo_zero;
      logic cnt_full;
      logic idx_zero;
      logic out_free;
   } sts_type;

endpackage

[rtl/any_base_radix_converter.sv]
// Any-base radix converter: decimal-coded source digits in, target digits out.
// Steps: a multiply and an accumulate per decimal digit (up to 10), a range check,
// the divider loop per target digit, a memory read, then one digit per cycle
// while rsp_ready is high.
// One item at a time; the divider loop sets the rate. Sync active-high reset,
// source_base 2 and target_base 10 after reset, no clearing pass.
module any_base_radix_converter #(
   parameter int VALUE_WIDTH = abrc_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = abrc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [abrc_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [abrc_pkg::CFG_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [abrc_pkg::N_W-1:0]         req_coded_number,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [abrc_pkg::DIGIT_W-1:0]     rsp_digit,
   output logic                             rsp_last,
   output logic [abrc_pkg::STATUS_W-1:0]    rsp_status
);
   import abrc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   abrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   abrc_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_coded_number (req_coded_number),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit        (rsp_digit),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

endmodule

[rtl/abrc_dpath.sv]
// Datapath: config registers, decimal digit split, value build-up, radix-16
// restoring divider, digit memory and output register. Uses abrc_pkg.
`include "any_base_radix_converter_defines.svh"

module abrc_dpath #(
   parameter int VALUE_WIDTH = abrc_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = abrc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [abrc_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [abrc_pkg::CFG_DATA_W-1:0]  csr_wdata,
   input  logic [abrc_pkg::N_W-1:0]         req_coded_number,
   input  abrc_pkg::cmd_type                cmd,
   output abrc_pkg::sts_type                sts,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [abrc_pkg::DIGIT_W-1:0]     rsp_digit,
   output logic                             rsp_last,
   output logic [abrc_pkg::STATUS_W-1:0]    rsp_status
);
   import abrc_pkg::*;

   localparam int DW     = (VALUE_WIDTH < ACC_W) ? VALUE_WIDTH : ACC_W;
   localparam int DIV_W  = ((DW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
   localparam int STEPS  = DIV_W / DIV_STEP;
   localparam int STEP_W = $clog2(STEPS);
   localparam int EXT_A  = (ACC_W > VALUE_WIDTH + 1) ? ACC_W : VALUE_WIDTH + 1;
   localparam int EXT_W  = (EXT_A > DIV_W) ? EXT_A : DIV_W;
   localparam int AW     = $clog2(MAX_DIGITS);
   localparam int CNT_W  = AW + 1;
   localparam int PROD_W = N_W + RECIP_W;
   localparam int Q_W    = PROD_W - RECIP_SHIFT;

   logic [SB_W-1:0]    sb_ff, sb_w;
   logic [TB_W-1:0]    tb_ff, tb_w;

   logic [N_W-1:0]     n_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [Q_W-1:0]     quot10;
   logic [N_W-1:0]     rem10;
   logic [DIGIT_W-1:0] dec_digit;
   logic [ACC_W-1:0]   value_ff, value_in;
   logic [ACC_W-1:0]   weight_ff, weight_in;
   logic [EXT_W-1:0]   value_ext;

   logic [DIV_W-1:0]   quo_ff, div_q;
   logic [TB_W-1:0]    rem_ff, div_r;
   logic [TB_W:0]      div_t;
   logic [STEP_W-1:0]  step_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [AW-1:0]      idx_ff, rd_addr;
   logic               div_last;

   logic [DIGIT_W-1:0] mem [MAX_DIGITS];
   logic [DIGIT_W-1:0] rd_data_ff;

   logic               rsp_valid_ff;
   logic [DIGIT_W-1:0] rsp_digit_ff;
   logic               rsp_last_ff;
   status_type         rsp_status_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff <= SB_MIN;
         tb_ff <= 5'd10;
      end else if (csr_we) begin
         case (csr_index)
            CFG_SOURCE_BASE: sb_ff <= csr_wdata[SB_W-1:0];
            CFG_TARGET_BASE: tb_ff <= csr_wdata[TB_W-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range bases saturate
   always_comb begin
      if (sb_ff < SB_MIN)      sb_w = SB_MIN;
      else if (sb_ff > SB_MAX) sb_w = SB_MAX;
      else                     sb_w = sb_ff;
      if (tb_ff < TB_MIN)      tb_w = TB_MIN;
      else if (tb_ff > TB_MAX) tb_w = TB_MAX;
      else                     tb_w = tb_ff;
   end

   // decimal digit split: reciprocal multiply, registered, then q*10 back-off
   assign prod_in   = PROD_W'(n_ff) * PROD_W'(RECIP_10);
   assign quot10    = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign rem10     = n_ff - N_W'({quot10, 3'b000}) - N_W'({quot10, 1'b0});
   assign dec_digit = rem10[DIGIT_W-1:0];
   assign value_in  = value_ff + weight_ff * ACC_W'(dec_digit);
   assign weight_in = weight_ff * ACC_W'(sb_w);
   assign value_ext = EXT_W'(value_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         n_ff      <= req_coded_number;
         value_ff  <= '0;
         weight_ff <= ACC_W'(1);
      end else if (cmd.acc) begin
         n_ff      <= N_W'(quot10);
         value_ff  <= value_in;
         weight_ff <= weight_in;
      end
      if (cmd.mul) prod_ff <= prod_in;
   end

   // four restoring steps per cycle; remainder stays below tb
   always_comb begin
      div_r = rem_ff;
      div_q = quo_ff;
      div_t = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         div_t = {div_r, div_q[DIV_W-1]};
         div_q = {div_q[DIV_W-2:0], 1'b0};
         if (div_t >= {1'b0, tb_w}) begin
            div_t    = div_t - {1'b0, tb_w};
            div_q[0] = 1'b1;
         end
         div_r = div_t[TB_W-1:0];
      end
   end

   assign div_last = (step_ff == STEP_W'(STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load_div) begin
         quo_ff <= value_ext[DIV_W-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= div_q;
         rem_ff <= div_last ? '0 : div_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.load_div) begin
         step_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         step_ff <= div_last ? '0 : step_ff + STEP_W'(1);
         if (div_last) cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // idx tracks the newest digit, then walks down while emitting
   always_ff @(posedge clock) begin
      if (cmd.div_step && div_last) idx_ff <= cnt_ff[AW-1:0];
      else if (cmd.dec_idx)         idx_ff <= idx_ff - AW'(1);
   end

   assign rd_addr = cmd.dec_idx ? idx_ff - AW'(1) : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_step && div_last) mem[cnt_ff[AW-1:0]] <= div_r[DIGIT_W-1:0];
      rd_data_ff <= mem[rd_addr];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_digit || cmd.load_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_digit) begin
         rsp_digit_ff  <= rd_data_ff;
         rsp_last_ff   <= (idx_ff == '0);
         rsp_status_ff <= ST_OK;
      end else if (cmd.load_err) begin
         rsp_digit_ff  <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= cmd.err_code;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digit  = rsp_digit_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   assign sts.n_zero    = (n_ff == '0);
   assign sts.bad_digit = (dec_digit >= sb_w);
   assign sts.overflow  = ((value_ext >> VALUE_WIDTH) != '0);
   assign sts.div_last  = div_last;
   assign sts.quo_zero  = (div_q == '0);
   assign sts.cnt_full  = (cnt_ff == CNT_W'(MAX_DIGITS - 1));
   assign sts.idx_zero  = (idx_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   `ABRC_ASSERT(a_rem_below_base, clock, reset, cmd.div_step |=> rem_ff < tb_w, "divider remainder not below target base")
   `ABRC_ASSERT_IMPLY(a_err_item_shape, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_last_ff && rsp_digit_ff == '0, "error item not a single zero digit")

endmodule

[rtl/abrc_ctrl.sv]
// Controller FSM: sequences digit split, range check, division and emission.
// Uses abrc_pkg; drives abrc_dpath through cmd_type and reads sts_type.
`include "any_base_radix_converter_defines.svh"

module abrc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  abrc_pkg::sts_type sts,
   output abrc_pkg::cmd_type cmd
);
   import abrc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DEC_MUL   = 8'b0000_0010,
      S_DEC_ACC   = 8'b0000_0100,
      S_CHECK     = 8'b0000_1000,
      S_DIV       = 8'b0001_0000,
      S_EMIT_READ = 8'b0010_0000,
      S_EMIT_PUSH = 8'b0100_0000,
      S_ERROR     = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   status_type err_code_ff, err_code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         err_code_ff <= ST_OK;
      end else begin
         state_ff    <= state_in;
         err_code_ff <= err_code_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      err_code_in  = err_code_ff;
      cmd          = '0;
      cmd.err_code = err_code_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DEC_MUL;
            end
         end
         S_DEC_MUL: begin
            if (sts.n_zero) begin
               state_in = S_CHECK;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DEC_ACC;
            end
         end
         S_DEC_ACC: begin
            if (sts.bad_digit) begin
               err_code_in = ST_BAD_DIGIT;
               state_in    = S_ERROR;
            end else begin
               cmd.acc  = 1'b1;
               state_in = S_DEC_MUL;
            end
         end
         S_CHECK: begin
            if (sts.overflow) begin
               err_code_in = ST_OVERFLOW;
               state_in    = S_ERROR;
            end else begin
               cmd.load_div = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               if (sts.quo_zero) begin
                  state_in = S_EMIT_READ;
               end else if (sts.cnt_full) begin
                  // more target digits than the buffer holds
                  err_code_in = ST_OVERFLOW;
                  state_in    = S_ERROR;
               end
            end
         end
         S_EMIT_READ: begin
            state_in = S_EMIT_PUSH;
         end
         S_EMIT_PUSH: begin
            if (sts.out_free) begin
               cmd.load_digit = 1'b1;
               if (sts.idx_zero) state_in    = S_IDLE;
               else              cmd.dec_idx = 1'b1;
            end
         end
         S_ERROR: begin
            if (sts.out_free) begin
               cmd.load_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ABRC_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.load_digit || cmd.load_err, sts.out_free, "output register loaded while occupied")
   `ABRC_ASSERT(a_last_digit_frees, clock, reset, cmd.load_digit && sts.idx_zero |=> req_ready, "not idle after last digit")

endmodule

[bench/any_base_radix_converter_tb.sv]
`timescale 1ns / 100ps
// Testbench for any_base_radix_converter: random and directed numbers under bursty
// input and a stalling receiver, every output digit checked against a local predictor.
// Depends on abrc_pkg and the any_base_radix_converter RTL only.

typedef struct packed {
   logic [abrc_pkg::DIGIT_W-1:0] digit;
   logic                         last;
   abrc_pkg::status_type         status;
} digit_result_type;

class radix_scoreboard;
   logic [abrc_pkg::SB_W-1:0] source_reg;
   logic [abrc_pkg::TB_W-1:0] target_reg;
   digit_result_type          expected_digits[$];
   int                        mismatches;

   function new();
      source_reg  = 4'd2;
      target_reg  = 5'd10;
      mismatches  = 0;
   endfunction

   function void write_reg(logic [abrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [abrc_pkg::CFG_DATA_W-1:0] data);
      if (idx == abrc_pkg::CFG_SOURCE_BASE) begin
         source_reg = data[abrc_pkg::SB_W-1:0];
      end else begin
         target_reg = data[abrc_pkg::TB_W-1:0];
      end
   endfunction

   // register values outside the legal range saturate
   function int unsigned source_radix();
      if (source_reg < abrc_pkg::SB_MIN) return 32'(abrc_pkg::SB_MIN);
      if (source_reg > abrc_pkg::SB_MAX) return 32'(abrc_pkg::SB_MAX);
      return 32'(source_reg);
   endfunction

   function int unsigned target_radix();
      if (target_reg < abrc_pkg::TB_MIN) return 32'(abrc_pkg::TB_MIN);
      if (target_reg > abrc_pkg::TB_MAX) return 32'(abrc_pkg::TB_MAX);
      return 32'(target_reg);
   endfunction

   function void push_result(logic [abrc_pkg::DIGIT_W-1:0] d, logic l,
                             abrc_pkg::status_type s);
      digit_result_type r;
      r.digit  = d;
      r.last   = l;
      r.status = s;
      expected_digits.push_back(r);
   endfunction

   function void note_number(logic [abrc_pkg::N_W-1:0] coded);
      longint unsigned num, value, weight, digit_val, radix_in, radix_out;
      logic [abrc_pkg::DIGIT_W-1:0] digs[abrc_pkg::MAX_DIGITS_DEF];
      int count;
      num       = 64'(coded);
      radix_in  = 64'(source_radix());
      radix_out = 64'(target_radix());
      value     = 0;
      weight    = 1;
      count     = 0;
      // bad digit is checked over the whole number before any overflow
      while (num != 0) begin
         digit_val = num % 10;
         if (digit_val >= radix_in) begin
            push_result('0, 1'b1, abrc_pkg::ST_BAD_DIGIT);
            return;
         end
         value  += digit_val * weight;
         weight *= radix_in;
         num    /= 10;
      end
      if ((value >> abrc_pkg::VALUE_WIDTH_DEF) != 0) begin
         push_result('0, 1'b1, abrc_pkg::ST_OVERFLOW);
         return;
      end
      if (value == 0) begin
         push_result('0, 1'b1, abrc_pkg::ST_OK);
         return;
      end
      while (value != 0) begin
         if (count >= abrc_pkg::MAX_DIGITS_DEF) begin
            push_result('0, 1'b1, abrc_pkg::ST_OVERFLOW);
            return;
         end
         digs[count] = abrc_pkg::DIGIT_W'(value % radix_out);
         value       = value / radix_out;
         count++;
      end
      for (int k = count - 1; k >= 0; k--) begin
         push_result(digs[k], k == 0, abrc_pkg::ST_OK);
      end
   endfunction

   function void check_digit(logic [abrc_pkg::DIGIT_W-1:0] d, logic l,
                             logic [abrc_pkg::STATUS_W-1:0] s);
      digit_result_type want;
      if (expected_digits.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: unexpected digit %0d last %0b status %0d", $realtime, d, l, s);
         end
         return;
      end
      want = expected_digits.pop_front();
      if (want.digit !== d || want.last !== l || want.status !== s) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: expected digit %0d last %0b status %0d, got %0d %0b %0d",
                     $realtime, want.digit, want.last, want.status, d, l, s);
         end
      end
   endfunction

   function int pending();
      return expected_digits.size();
   endfunction
endclass

module any_base_radix_converter_tb;
   import abrc_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_ITEM  = 120;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 23;
   localparam int FLUSH_CYCLES  = 320;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_we           = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index        = CFG_SOURCE_BASE;
   logic [CFG_DATA_W-1:0] csr_wdata        = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [N_W-1:0]        req_coded_number = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [DIGIT_W-1:0]    rsp_digit;
   logic                  rsp_last;
   logic [STATUS_W-1:0]   rsp_status;

   radix_scoreboard scoreboard = new();
   logic [N_W-1:0]  stim_q[$];
   int              items_sent   = 0;
   int              burst_left   = 1;
   bit              hold_request = 1'b0;

   any_base_radix_converter DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coded_number (req_coded_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit        (rsp_digit),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) scoreboard.check_digit(rsp_digit, rsp_last, rsp_status);
         if (req_valid && req_ready) scoreboard.note_number(req_coded_number);
         if (csr_we) scoreboard.write_reg(csr_index, csr_wdata);
      end
   end

   // mostly numbers whose digits are legal in the source base, some with one bad
   // digit planted, some raw 31-bit noise
   function automatic logic [N_W-1:0] random_coded(int unsigned radix);
      longint unsigned v;
      int unsigned     dv;
      int              pick, ndig, pos;
      pick = $urandom_range(0, 99);
      if (pick >= 85) return N_W'($urandom);
      ndig = $urandom_range(1, 10);
      pos  = $urandom_range(0, ndig - 1);
      v    = 0;
      for (int i = 0; i < ndig; i++) begin
         if (pick >= 70 && radix < 10 && i == pos) dv = $urandom_range(radix, 9);
         else dv = $urandom_range(0, radix - 1);
         v = v * 10 + 64'(dv);
      end
      if (v > 64'd2147483647) v = v % 1000000000;
      return v[N_W-1:0];
   endfunction

   task automatic offer(input logic [N_W-1:0] coded);
      int pause;
      req_valid        <= 1'b1;
      req_coded_number <= coded;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (items_sent == HOLD_AT_ITEM) hold_request = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (pause != 0) begin
            req_valid <= 1'b0;
            repeat (pause) @(negedge clock);
         end
      end
   endtask

   // entered and left at a falling edge with the block idle
   task automatic run_phase(input bit write_cfg, input logic [CFG_DATA_W-1:0] src_w,
                            input logic [CFG_DATA_W-1:0] tgt_w, input int random_count);
      if (write_cfg) begin
         csr_we    <= 1'b1;
         csr_index <= CFG_SOURCE_BASE;
         csr_wdata <= src_w;
         @(negedge clock);
         csr_index <= CFG_TARGET_BASE;
         csr_wdata <= tgt_w;
         @(negedge clock);
         csr_we    <= 1'b0;
      end
      repeat (random_count) stim_q.push_back(random_coded(scoreboard.source_radix()));
      while (stim_q.size() != 0) offer(stim_q.pop_front());
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: changing stall patterns plus one long hold-off
   initial begin
      int mode, mode_left, tick;
      bit take;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         tick++;
         case (mode)
            0: begin
               take = 1'b1;
            end
            1: begin
               take = 1'($urandom_range(0, 1));
            end
            2: begin
               take = (tick % 3 == 0);
            end
            default: begin
               take = ($urandom_range(0, 4) != 0);
            end
         endcase
         rsp_ready <= take;
      end
   end

   // cycles with neither channel moving an item
   initial begin
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stalled_cycles = 0;
         else stalled_cycles++;
      end
      $display("any_base_radix_converter verification failed");
      $finish;
   end

   initial begin
      logic [CFG_DATA_W-1:0] src_w, tgt_w;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset bases: binary in, decimal out
      stim_q = '{31'd0, 31'd1, 31'd10, 31'd11, 31'd1111111111, 31'd1000000000,
                 31'd2, 31'd2147483647};
      run_phase(1'b0, '0, '0, 0);
      stim_q = '{31'd2147483647, 31'd9, 31'd15, 31'd16, 31'd0};
      run_phase(1'b1, 5'd10, 5'd16, 0);
      // widest output: 31 binary digits
      stim_q = '{31'd2147483647, 31'd1};
      run_phase(1'b1, 5'd10, 5'd2, 0);
      // both bases saturate
      stim_q = '{31'd1111111111, 31'd2};
      run_phase(1'b1, 5'd0, 5'd31, 0);
      stim_q = '{31'd7, 31'd1234567890};
      run_phase(1'b1, 5'd15, 5'd1, 0);
      // bit 4 of a source base write is dropped
      stim_q = '{31'd101};
      run_phase(1'b1, 5'd16, 5'd0, 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         src_w = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                             : CFG_DATA_W'($urandom_range(2, 10));
         tgt_w = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                             : CFG_DATA_W'($urandom_range(2, 16));
         run_phase(1'b1, src_w, tgt_w, PHASE_ITEMS);
      end

      repeat (FLUSH_CYCLES) @(posedge clock);
      if (scoreboard.pending() != 0) begin
         $display("%0d expected digits never arrived", scoreboard.pending());
      end
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("any_base_radix_converter verification clean");
      end else begin
         $display("any_base_radix_converter verification failed");
      end
      $finish;
   end
endmodule
